// ===== rtl/csi_pkg.sv =====
// ----------------------------------------------------------------------------
// csi_pkg
// Shared types and constants of the complex spike index core.
// ----------------------------------------------------------------------------
package csi_pkg;

  // Field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned GAP_W     = 20;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned SCORE_W   = 21;
  localparam int unsigned POINTS_W  = 20;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 80;

  // Quotient bits of the index divide: |index| <= 25600 < 2^15
  localparam int unsigned QUOT_W    = 15;
  localparam int unsigned QCNT_W    = 4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd2;

  // Register reset values
  localparam logic [GAP_W-1:0] MIN_GAP_RST = 20'd3000;
  localparam logic [GAP_W-1:0] MAX_GAP_RST = 20'd15000;

  // Scoring modes
  localparam logic MODE_COMPLEX = 1'b0;
  localparam logic MODE_SINGLE  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SEL,
    ST_UPD,
    ST_START,
    ST_DIV,
    ST_OUT
  } csi_state_t;

  // Control strobes from the sequencer to the scoring datapath
  typedef struct packed {
    logic load;   // capture an accepted item
    logic diff;   // form neighbour time and height differences
    logic sel;    // pick the nearer neighbour, form gap magnitude
    logic upd;    // score, shift the window, count the point
    logic clr;    // clear the record
  } csi_ctl_t;

endpackage

// ===== rtl/complex_spike_index_core.sv =====
// ----------------------------------------------------------------------------
// complex_spike_index_core
// Streaming complex spike index over a record of spike events.
// ----------------------------------------------------------------------------
// Usage:
//   Spike items enter on the in_ stream (time, signed height, tlast marks the
//   final spike of a record). Each interior spike is scored against its
//   nearer neighbour, if within max gap, in a three-spike window. On the
//   final spike one result item leaves on the out_ stream: index
//   (100*score/points, signed Q8, truncated), score, scored and total points.
//   Sequence: an item that is not the last passes through accept, difference,
//   select and update; in_tready is high only while the sequencer is idle.
//   A final spike then starts the restoring divider (15 quotient bits, one a
//   cycle, then a done flag) and loads the output register once it is free.
//   The output register holds a result until out_tready; new spikes are
//   taken meanwhile, and only the next final spike waits for the register.
//   Reset (rst_n low, synchronous) clears the record, drops any pending
//   result and restores the register defaults. Write cfg_ only while idle.
// ----------------------------------------------------------------------------
module complex_spike_index_core #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: spike_time[31:0], spike_height[47:32]
  input  logic [csi_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: index_q8[15:0], score[36:16], scored_points[56:37],
  //            total_points[76:57], zero fill [79:77]
  output logic [csi_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [csi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csi_pkg::GAP_W-1:0]          cfg_wdata
);

  csi_pkg::csi_state_t state_r, state_nxt;
  csi_pkg::csi_ctl_t   ctl;

  logic [csi_pkg::GAP_W-1:0] min_gap_r, max_gap_r;
  logic                      score_mode_r;
  logic                      last_r;
  logic                      div_start, div_done, out_load;
  logic [csi_pkg::QUOT_W-1:0] quot;

  logic signed [COUNT_BITS:0] score_sum;
  logic [COUNT_BITS-1:0]      scored_count, point_count;
  logic [COUNT_BITS-1:0]      score_mag;

  logic signed [32:0]             score_ext;
  logic [31:0]                    scored_ext, points_ext;
  logic signed [csi_pkg::INDEX_W-1:0] index_val;

  logic [csi_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                           out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r    <= csi_pkg::MIN_GAP_RST;
      max_gap_r    <= csi_pkg::MAX_GAP_RST;
      score_mode_r <= csi_pkg::MODE_COMPLEX;
    end else if (cfg_we) begin
      case (cfg_index)
        csi_pkg::REG_MIN_GAP: min_gap_r    <= cfg_wdata;
        csi_pkg::REG_MAX_GAP: max_gap_r    <= cfg_wdata;
        csi_pkg::REG_MODE:    score_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the last flag of the item in flight
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      last_r <= in_tlast;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csi_pkg::ST_IDLE:  if (in_tvalid) state_nxt = csi_pkg::ST_DIFF;
      csi_pkg::ST_DIFF:  state_nxt = csi_pkg::ST_SEL;
      csi_pkg::ST_SEL:   state_nxt = csi_pkg::ST_UPD;
      csi_pkg::ST_UPD:   state_nxt = last_r ? csi_pkg::ST_START : csi_pkg::ST_IDLE;
      csi_pkg::ST_START: state_nxt = csi_pkg::ST_DIV;
      csi_pkg::ST_DIV:   if (div_done) state_nxt = csi_pkg::ST_OUT;
      csi_pkg::ST_OUT:   if (!out_valid_r || out_tready) state_nxt = csi_pkg::ST_IDLE;
      default:           state_nxt = csi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    ctl       = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      csi_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
      end
      csi_pkg::ST_DIFF:  ctl.diff  = 1'b1;
      csi_pkg::ST_SEL:   ctl.sel   = 1'b1;
      csi_pkg::ST_UPD:   ctl.upd   = 1'b1;
      csi_pkg::ST_START: div_start = 1'b1;
      csi_pkg::ST_OUT: begin
        out_load = !out_valid_r || out_tready;
        ctl.clr  = out_load;
      end
      default: ;
    endcase
  end

  csi_score #(
    .COUNT_BITS (COUNT_BITS)
  ) u_score (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .spike_time   (in_tdata[csi_pkg::TIME_W-1:0]),
    .spike_height (in_tdata[csi_pkg::TIME_W +: csi_pkg::HEIGHT_W]),
    .min_gap      (min_gap_r),
    .max_gap      (max_gap_r),
    .score_mode   (score_mode_r),
    .score_sum    (score_sum),
    .scored_count (scored_count),
    .point_count  (point_count)
  );

  // |score| never exceeds the point count, so it fits the count width
  assign score_mag = score_sum[COUNT_BITS] ? COUNT_BITS'(-score_sum)
                                           : score_sum[COUNT_BITS-1:0];

  csi_div #(
    .DEN_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (score_mag),
    .den   (point_count),
    .done  (div_done),
    .quot  (quot)
  );

  // Assemble the result
  always_comb begin
    score_ext  = 33'(score_sum);
    scored_ext = 32'(scored_count);
    points_ext = 32'(point_count);
    if (scored_count == '0) begin
      index_val = '0;
    end else if (score_sum[COUNT_BITS]) begin
      index_val = -$signed({1'b0, quot});
    end else begin
      index_val = $signed({1'b0, quot});
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'b000,
                     points_ext[csi_pkg::POINTS_W-1:0],
                     scored_ext[csi_pkg::POINTS_W-1:0],
                     score_ext[csi_pkg::SCORE_W-1:0],
                     index_val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_scored_le_points: assert property (@(posedge clk) disable iff (!rst_n)
    scored_count <= point_count)
    else $error("scored count exceeds point count");

  a_score_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    score_mag <= scored_count)
    else $error("score magnitude exceeds scored count");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == csi_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (quot <= csi_pkg::QUOT_W'(25600)))
    else $error("index quotient out of range");

  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (point_count == '0) && (scored_count == '0) && out_tvalid)
    else $error("record not cleared after result load");
`endif

endmodule

// ===== rtl/csi_score.sv =====
// ----------------------------------------------------------------------------
// csi_score
// Three-spike window, nearer-neighbour scoring and record counters.
// ----------------------------------------------------------------------------
module csi_score #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csi_pkg::csi_ctl_t                   ctl,
  input  logic [csi_pkg::TIME_W-1:0]          spike_time,
  input  logic signed [csi_pkg::HEIGHT_W-1:0] spike_height,
  input  logic [csi_pkg::GAP_W-1:0]           min_gap,
  input  logic [csi_pkg::GAP_W-1:0]           max_gap,
  input  logic                                score_mode,
  output logic signed [COUNT_BITS:0]          score_sum,
  output logic [COUNT_BITS-1:0]               scored_count,
  output logic [COUNT_BITS-1:0]               point_count
);

  localparam int unsigned TW = csi_pkg::TIME_W;
  localparam int unsigned HW = csi_pkg::HEIGHT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [COUNT_BITS+1:0] SUM_MAX = {2'b00, {COUNT_BITS{1'b1}}};
  localparam logic signed [COUNT_BITS+1:0] SUM_MIN = -SUM_MAX;

  logic [TW-1:0]        new_time_r, mid_time_r, old_time_r;
  logic signed [HW-1:0] new_height_r, mid_height_r, old_height_r;
  logic signed [TW:0]   d1_r, d2_r;
  logic signed [HW:0]   ht_old_r, ht_new_r;
  logic [TW-1:0]        mag_r;
  logic                 gap_neg_r, gap_zero_r, ht_pos_r;
  logic signed [COUNT_BITS:0] sum_r;
  logic [COUNT_BITS-1:0]      scored_r, points_r;

  logic signed [TW:0]   gap;
  logic signed [HW:0]   ht;
  logic                 near_old;
  logic                 in_reach, below_min, gap_pos;
  logic signed [1:0]    delta;
  logic                 do_score;
  logic signed [COUNT_BITS+1:0] sum_wide;

  // Capture the item and form both neighbour differences
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      new_time_r   <= spike_time;
      new_height_r <= spike_height;
    end
    if (ctl.diff) begin
      d1_r     <= $signed({1'b0, mid_time_r}) - $signed({1'b0, old_time_r});
      d2_r     <= $signed({1'b0, new_time_r}) - $signed({1'b0, mid_time_r});
      ht_old_r <= $signed({mid_height_r[HW-1], mid_height_r})
                - $signed({old_height_r[HW-1], old_height_r});
      ht_new_r <= $signed({mid_height_r[HW-1], mid_height_r})
                - $signed({new_height_r[HW-1], new_height_r});
    end
  end

  // Pick the nearer neighbour
  always_comb begin
    near_old = d1_r < d2_r;
    gap      = near_old ? d1_r : -d2_r;
    ht       = near_old ? ht_old_r : ht_new_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.sel) begin
      mag_r      <= gap[TW] ? TW'(-gap) : gap[TW-1:0];
      gap_neg_r  <= gap[TW];
      gap_zero_r <= (gap == '0);
      ht_pos_r   <= !ht[HW] && (ht != '0);
    end
  end

  // Score the middle spike
  always_comb begin
    in_reach  = mag_r <= TW'(max_gap);
    below_min = mag_r < TW'(min_gap);
    gap_pos   = !gap_neg_r && !gap_zero_r;
    delta     = 2'sd0;
    if (below_min) begin
      delta = -2'sd1;
    end else if (score_mode == csi_pkg::MODE_COMPLEX) begin
      if (!ht_pos_r && gap_pos) begin
        delta = 2'sd1;
      end else if (ht_pos_r && gap_neg_r) begin
        delta = 2'sd1;
      end else if (!gap_zero_r) begin
        delta = -2'sd1;
      end
    end
    do_score = (points_r >= COUNT_BITS'(2)) && in_reach;
    sum_wide = $signed({sum_r[COUNT_BITS], sum_r}) + (COUNT_BITS+2)'(delta);
    if (sum_wide > SUM_MAX) begin
      sum_wide = SUM_MAX;
    end else if (sum_wide < SUM_MIN) begin
      sum_wide = SUM_MIN;
    end
  end

  // Window shift and counters
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      old_time_r   <= '0;
      old_height_r <= '0;
      mid_time_r   <= '0;
      mid_height_r <= '0;
      sum_r        <= '0;
      scored_r     <= '0;
      points_r     <= '0;
    end else if (ctl.upd) begin
      if (do_score) begin
        sum_r <= sum_wide[COUNT_BITS:0];
        if (scored_r != CNT_MAX) begin
          scored_r <= scored_r + 1'b1;
        end
      end
      old_time_r   <= mid_time_r;
      old_height_r <= mid_height_r;
      mid_time_r   <= new_time_r;
      mid_height_r <= new_height_r;
      if (points_r != CNT_MAX) begin
        points_r <= points_r + 1'b1;
      end
    end
  end

  assign score_sum    = sum_r;
  assign scored_count = scored_r;
  assign point_count  = points_r;

endmodule

// ===== rtl/csi_div.sv =====
// ----------------------------------------------------------------------------
// csi_div
// Restoring divider: one compare-subtract per cycle for 25600*mag / den.
// ----------------------------------------------------------------------------
module csi_div #(
  parameter int unsigned DEN_W = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DEN_W-1:0]              mag,
  input  logic [DEN_W-1:0]              den,
  output logic                          done,
  output logic [csi_pkg::QUOT_W-1:0]    quot
);

  localparam int unsigned QW    = csi_pkg::QUOT_W;
  localparam int unsigned NUM_W = DEN_W + QW;

  logic [NUM_W-1:0]            prod;
  logic [DEN_W-1:0]            rem_r;
  logic [QW-1:0]               num_r, quot_r;
  logic [csi_pkg::QCNT_W-1:0]  cnt_r;
  logic                        busy_r, done_r;
  logic [DEN_W:0]              trial, diff;
  logic                        fits;

  // Scale by 25600 = 2^14 + 2^13 + 2^10
  assign prod = (NUM_W'(mag) << 14) + (NUM_W'(mag) << 13) + (NUM_W'(mag) << 10);

  // One restoring step
  always_comb begin
    trial = {rem_r, num_r[QW-1]};
    diff  = trial - {1'b0, den};
    fits  = !diff[DEN_W];
  end

  // Datapath: the high part of the product is already below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= prod[NUM_W-1:QW];
      num_r  <= prod[QW-1:0];
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r  <= {num_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], fits};
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= csi_pkg::QCNT_W'(QW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
